[hw/rtl/msh_pkg.sv]
// msh_pkg: shared types, register indexes and constants for the modular string hash unit
// no dependencies; used by msh_ctrl, msh_datapath and modular_string_hash_unit

package msh_pkg;

    localparam int HASH_W  = 24;
    localparam int LEN_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int SHQ_W   = 32;
    localparam int CNT_W   = 6;
    localparam int CFG_IDX_W = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_REQUESTED_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_MODE      = 8'd1;

    // reduction step counts: short path shifts in the seven low byte bits,
    // long path shifts in the whole 32-bit product
    localparam logic [CNT_W-1:0] FAST_STEPS = 6'd7;
    localparam logic [CNT_W-1:0] SLOW_STEPS = 6'd32;

    localparam logic [HASH_W-1:0] RESET_SIZE = 24'd65521;

    localparam logic [BYTE_W-1:0] CHAR_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET    = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;

    localparam int PRIME_COUNT = 13;
    localparam logic [HASH_W-1:0] PRIME_LIST [PRIME_COUNT] = '{
        24'd101, 24'd1009, 24'd7919, 24'd8191, 24'd10039, 24'd16381, 24'd17389,
        24'd32749, 24'd65521, 24'd100003, 24'd131071, 24'd500009, 24'd1000003
    };

    typedef struct packed {
        logic capture;
        logic load_fast;
        logic load_slow;
        logic correct;
        logic shift;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic counts;
        logic last;
        logic hash_lt_mod;
        logic mod_zero;
    } sts_t;

    // smallest listed prime not below the request; zero gives zero, large requests pass through
    function automatic logic [HASH_W-1:0] round_size(input logic [HASH_W-1:0] req);
        logic [HASH_W-1:0] m;
        m = req;
        for (int k = PRIME_COUNT - 1; k >= 0; k--) begin
            if (req <= PRIME_LIST[k]) begin
                m = PRIME_LIST[k];
            end
        end
        if (req == '0) begin
            m = '0;
        end
        return m;
    endfunction

endpackage

[hw/rtl/msh_ctrl.sv]
// msh_ctrl: sequencer for the string hash unit, drives the datapath by command struct
// depends on msh_pkg (cmd_t, sts_t, step counts)

module msh_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output msh_pkg::cmd_t cmd,
    input  msh_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CORRECT,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t                        state_reg;
    logic [msh_pkg::CNT_W-1:0]     cnt_reg;
    logic                          m_valid_reg;
    logic                          out_blocked;

    assign out_blocked = m_valid_reg && !m_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
            end
            ST_DECIDE: begin
                if (sts.counts && !sts.mod_zero) begin
                    cmd.load_fast = sts.hash_lt_mod;
                    cmd.load_slow = !sts.hash_lt_mod;
                end
            end
            ST_CORRECT: begin
                cmd.correct = 1'b1;
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
            end
            ST_FINISH: begin
                cmd.push = sts.last && !out_blocked;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= cmd.push || out_blocked;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (cmd.load_fast) begin
                        cnt_reg   <= msh_pkg::FAST_STEPS;
                        state_reg <= ST_CORRECT;
                    end else if (cmd.load_slow) begin
                        cnt_reg   <= msh_pkg::SLOW_STEPS;
                        state_reg <= ST_SHIFT;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_CORRECT: begin
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!sts.last || !out_blocked) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !out_blocked)
        else $error("result pushed over an untaken result");

    // the step counter never runs out inside the shift loop
    a_shift_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (cnt_reg != '0))
        else $error("shift state with empty step counter");

    // an accepted transfer always goes to the decide step
    a_accept_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECIDE))
        else $error("accepted transfer not followed by decide");

    // a result appears only out of the finish step
    a_push_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (state_reg == ST_FINISH) && sts.last)
        else $error("push outside finish of a last byte");

endmodule

[hw/rtl/msh_datapath.sv]
// msh_datapath: config registers, string state, byte filter and restoring modulo reducer
// depends on msh_pkg (cmd_t, sts_t, round_size, character constants)

module msh_datapath #(
    parameter int MAX_SPAN = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [msh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msh_pkg::HASH_W-1:0]      cfg_data,
    input  logic [msh_pkg::BYTE_W-1:0]      s_byte_value,
    input  logic [msh_pkg::LEN_W-1:0]       s_string_length,
    input  logic                            s_first_byte,
    input  logic                            s_last_byte,
    input  msh_pkg::cmd_t                   cmd,
    output msh_pkg::sts_t                   sts,
    output logic [msh_pkg::HASH_W-1:0]      m_bucket_index
);

    localparam logic [msh_pkg::LEN_W-1:0] SPAN = msh_pkg::LEN_W'(MAX_SPAN);

    logic [msh_pkg::HASH_W-1:0] modulus_reg;
    logic                       mode_reg;
    logic [msh_pkg::LEN_W-1:0]  seed_len_reg,  seed_len_next;
    logic [msh_pkg::LEN_W-1:0]  pos_reg,       pos_next;
    logic                       stopped_reg,   stopped_next;
    logic [msh_pkg::HASH_W-1:0] hash_reg,      hash_next;
    logic [msh_pkg::SHQ_W-1:0]  shq_reg,       shq_next;
    logic [msh_pkg::BYTE_W-1:0] ch_reg,        ch_next;
    logic                       count_reg,     count_next;
    logic                       last_reg,      last_next;
    logic [msh_pkg::HASH_W-1:0] bucket_reg;

    logic [msh_pkg::LEN_W-1:0]  len_eff, pos_eff, span_start, len_cap;
    logic                       stop_eff, in_range, counts_c, stop_c;
    logic [msh_pkg::BYTE_W-1:0] ch_map;
    logic [msh_pkg::HASH_W:0]   step_opnd, step_diff;
    logic                       step_ge;
    logic [msh_pkg::HASH_W-1:0] step_red;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= msh_pkg::round_size(msh_pkg::RESET_SIZE);
            mode_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                msh_pkg::REG_REQUESTED_SIZE: begin
                    modulus_reg <= msh_pkg::round_size(cfg_data);
                end
                msh_pkg::REG_PATH_MODE: begin
                    mode_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // byte filter on the incoming item
    always_comb begin
        len_eff    = s_first_byte ? s_string_length : seed_len_reg;
        pos_eff    = s_first_byte ? '0 : pos_reg;
        stop_eff   = s_first_byte ? 1'b0 : stopped_reg;
        span_start = (len_eff > SPAN) ? len_eff - SPAN : '0;
        len_cap    = (len_eff > SPAN) ? SPAN : len_eff;
        in_range   = !stop_eff && (pos_eff < len_cap);
        if (mode_reg) begin
            counts_c = in_range && (s_byte_value != msh_pkg::CHAR_NUL);
            stop_c   = stop_eff || (in_range && (s_byte_value == msh_pkg::CHAR_NUL));
        end else begin
            counts_c = (pos_eff < len_eff) && (pos_eff >= span_start);
            stop_c   = stop_eff;
        end
        ch_map = s_byte_value;
        if (mode_reg) begin
            if (s_byte_value == msh_pkg::CHAR_SLASH) begin
                ch_map = msh_pkg::CHAR_BACKSLASH;
            end else if (s_byte_value >= msh_pkg::CHAR_LOWER_A &&
                         s_byte_value <= msh_pkg::CHAR_LOWER_Z) begin
                ch_map = s_byte_value - msh_pkg::CASE_OFFSET;
            end
        end
    end

    // one restoring step, shared by the correction and shift steps
    always_comb begin
        step_opnd = cmd.shift ? {hash_reg, shq_reg[msh_pkg::SHQ_W-1]} : {1'b0, hash_reg};
        step_ge   = step_opnd >= {1'b0, modulus_reg};
        step_diff = step_opnd - {1'b0, modulus_reg};
        step_red  = step_ge ? step_diff[msh_pkg::HASH_W-1:0]
                            : step_opnd[msh_pkg::HASH_W-1:0];
    end

    always_comb begin
        seed_len_next = seed_len_reg;
        pos_next      = pos_reg;
        stopped_next  = stopped_reg;
        hash_next     = hash_reg;
        shq_next      = shq_reg;
        ch_next       = ch_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        if (cmd.capture) begin
            seed_len_next = len_eff;
            pos_next      = (pos_eff == '1) ? pos_eff : pos_eff + 1'b1;
            stopped_next  = stop_c;
            hash_next     = s_first_byte ? msh_pkg::HASH_W'(s_string_length) : hash_reg;
            ch_next       = ch_map;
            count_next    = counts_c;
            last_next     = s_last_byte;
        end else if (cmd.load_fast) begin
            // hash below modulus: hash plus the top byte bit is at most the modulus
            hash_next = hash_reg + msh_pkg::HASH_W'(ch_reg[msh_pkg::BYTE_W-1]);
            shq_next  = {ch_reg[msh_pkg::BYTE_W-2:0], (msh_pkg::SHQ_W-msh_pkg::BYTE_W+1)'(0)};
        end else if (cmd.load_slow) begin
            hash_next = '0;
            shq_next  = msh_pkg::SHQ_W'({hash_reg, 7'd0}) + msh_pkg::SHQ_W'(ch_reg);
        end else if (cmd.correct) begin
            hash_next = step_red;
        end else if (cmd.shift) begin
            hash_next = step_red;
            shq_next  = {shq_reg[msh_pkg::SHQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_len_reg <= '0;
            pos_reg      <= '0;
            stopped_reg  <= 1'b0;
            hash_reg     <= '0;
            count_reg    <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            seed_len_reg <= seed_len_next;
            pos_reg      <= pos_next;
            stopped_reg  <= stopped_next;
            hash_reg     <= hash_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        shq_reg <= shq_next;
        ch_reg  <= ch_next;
        if (cmd.push) begin
            bucket_reg <= (modulus_reg == '0) ? '0 : hash_reg;
        end
    end

    assign sts.counts      = count_reg;
    assign sts.last        = last_reg;
    assign sts.hash_lt_mod = hash_reg < modulus_reg;
    assign sts.mod_zero    = (modulus_reg == '0);
    assign m_bucket_index  = bucket_reg;

endmodule

[hw/rtl/modular_string_hash_unit.sv]
// modular_string_hash_unit: one string byte per transfer, shift-add hash modulo a prime size
// a byte that is not hashed goes from decide straight to finish; when the hash is below the
// modulus it takes a load, one correction and seven restoring steps, 32 restoring steps when not;
// the result is registered out of the finish step; one item at a time, no new byte is accepted
// before the unit is back in idle; a last byte waits in its finish step while an earlier result is untaken
// reset (aresetn, synchronous): hash state cleared, size 65521, unix path mode, no result

module modular_string_hash_unit #(
    parameter int MAX_SPAN = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [msh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msh_pkg::HASH_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [msh_pkg::BYTE_W-1:0]      s_byte_value,
    input  logic [msh_pkg::LEN_W-1:0]       s_string_length,
    input  logic                            s_first_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [msh_pkg::HASH_W-1:0]      m_bucket_index
);

    msh_pkg::cmd_t cmd;
    msh_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    msh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    msh_datapath #(
        .MAX_SPAN (MAX_SPAN)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_byte_value    (s_byte_value),
        .s_string_length (s_string_length),
        .s_first_byte    (s_first_byte),
        .s_last_byte     (s_last_byte),
        .cmd             (cmd),
        .sts             (sts),
        .m_bucket_index  (m_bucket_index)
    );

endmodule
